[sv/mlp_pkg.sv]
`timescale 1ns / 1ps
// Package for the backpropagation training block: payload structs, request and
// class codes, controller states and the sigmoid table generator.
// No dependencies.
package mlp_pkg;

    localparam int HIDDEN_UNITS_DEF  = 4;
    localparam int INPUT_UNITS_DEF   = 3;
    localparam int SIGMOID_DEPTH_DEF = 256;

    localparam logic [15:0] LEARN_RATE_RESET = 16'd2867;
    localparam logic [12:0] ONE_Q12          = 13'd4096;
    localparam logic [12:0] CLASS_LOW_MAX    = 13'd860;
    localparam logic [12:0] CLASS_HIGH_MIN   = 13'd3277;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_TRAIN = 2'd1;
    localparam logic [1:0] REQ_EVAL  = 2'd2;

    localparam logic [1:0] CLASS_LOW   = 2'd0;
    localparam logic [1:0] CLASS_HIGH  = 2'd1;
    localparam logic [1:0] CLASS_UNDEC = 2'd2;

    typedef struct packed {
        logic        [1:0]  req_type;
        logic        [4:0]  weight_index;
        logic signed [15:0] weight_value;
        logic signed [15:0] input_a;
        logic signed [15:0] input_b;
        logic        [12:0] target;
    } t_item;

    typedef struct packed {
        logic [12:0] net_output;
        logic [11:0] pattern_error;
        logic [1:0]  class_code;
        logic        hit;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD_H,
        ST_WAIT_H,
        ST_FWD_O,
        ST_WAIT_O,
        ST_SCAL,
        ST_DH,
        ST_UPD,
        ST_FLUSH
    } t_state;

    // Shift-and-subtract division, only used while building constant tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid table entry k in Q0.12 over [-8,8) split into depth cells.
    function automatic logic [12:0] sig_entry(input int k, input int depth);
        logic [63:0] twice;
        logic [63:0] dd;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] u;
        logic [63:0] t;
        logic [63:0] num;
        logic [63:0] den;
        logic        pos;
        twice = 64'(2 * k + 1);
        pos   = twice >= 64'(depth);
        dd    = pos ? twice - 64'(depth) : 64'(depth) - twice;
        f     = udiv64(dd << 30, 64'(depth));
        term  = 64'd1 << 30;
        u     = term;
        for (int n = 1; n <= 16; n++) begin
            term = udiv64((term * f) >> 30, 64'(n));
            u    = u + term;
        end
        t = udiv64(64'd1 << 60, u);
        for (int n = 0; n < 3; n++) begin
            t = (t * t) >> 30;
        end
        num = 64'd4096 * (pos ? (64'd1 << 30) : t);
        den = (64'd1 << 30) + t;
        return 13'(udiv64(num + (den >> 1), den));
    endfunction

endpackage

[sv/mlp_backprop_train_step.sv]
`timescale 1ns / 1ps
// A weight write or unknown request strobes in the cycle after start; an evaluation or a
// training pass strobes when its sequence is through, all its products made on the one
// shared multiplier and all weights read through the one read port of the weight memory.
// One item at a time; the result strobe cannot be stalled. Synchronous reset
// zeroes all weights (per-entry valid bits) and loads the learning rate 0.7.
module mlp_backprop_train_step #(
    parameter int HIDDEN_UNITS  = mlp_pkg::HIDDEN_UNITS_DEF,
    parameter int INPUT_UNITS   = mlp_pkg::INPUT_UNITS_DEF,
    parameter int SIGMOID_DEPTH = mlp_pkg::SIGMOID_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mlp_pkg::t_item   i_item,
    output logic             o_strobe,
    output mlp_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data
);
    import mlp_pkg::*;

    localparam int IH  = INPUT_UNITS * HIDDEN_UNITS;
    localparam int NW  = IH + HIDDEN_UNITS + 1;
    localparam int AW  = $clog2(NW);
    localparam int IXW = $clog2(INPUT_UNITS);
    localparam int JW  = $clog2(HIDDEN_UNITS + 1);
    localparam int SW  = $clog2(SIGMOID_DEPTH);

    // Sigmoid table.
    logic [12:0] w_rom [SIGMOID_DEPTH];
    for (genvar k = 0; k < SIGMOID_DEPTH; k++) begin : g_rom
        localparam logic [12:0] ENTRY = sig_entry(k, SIGMOID_DEPTH);
        assign w_rom[k] = ENTRY;
    end

    t_state r_state, n_state;
    logic [IXW-1:0] r_i, n_i;
    logic [JW-1:0]  r_j, n_j;
    logic [2:0]     r_step, n_step;

    logic [15:0]        r_lr;
    logic [1:0]         r_req;
    logic [12:0]        r_tgt;
    logic signed [15:0] r_x [INPUT_UNITS];
    logic [12:0]        r_h [HIDDEN_UNITS + 1];
    logic signed [33:0] r_lrdh [HIDDEN_UNITS + 1];

    // Weight memory with valid bits standing in for the zero reset.
    logic signed [15:0] r_mem [NW];
    logic [NW-1:0]      r_wvalid;
    logic signed [15:0] r_rd;
    logic               r_rdv;
    logic signed [15:0] rd_eff;
    logic [AW-1:0]      ra, wa;
    logic signed [15:0] wd;
    logic               mem_we;

    logic signed [33:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [57:0] r_prod;

    // Forward dot-product pipeline tags.
    logic               iss_v, iss_first, iss_last, iss_out;
    logic [JW-1:0]      iss_j;
    logic signed [15:0] iss_op;
    logic               r_t1v, r_t1first, r_t1last, r_t1out;
    logic [JW-1:0]      r_t1j;
    logic signed [15:0] r_op;
    logic               r_t2v, r_t2first, r_t2last, r_t2out;
    logic [JW-1:0]      r_t2j;
    logic               r_t3v, r_t3out;
    logic [JW-1:0]      r_t3j;
    logic               r_t4v, r_t4out;
    logic [JW-1:0]      r_t4j;
    logic signed [39:0] r_acc, acc_next, acc_shr;
    logic signed [15:0] r_sum, sum_clamp;
    logic [SW-1:0]      r_sidx;
    logic [31:0]        sidx_wide;
    logic               pipe_empty;

    logic [12:0]        r_o;
    logic [11:0]        r_err;
    logic signed [15:0] r_do;
    logic signed [33:0] r_lrdo;
    logic signed [23:0] r_q;

    logic               upd_iss, r_u1v;
    logic [AW-1:0]      r_u1addr;
    logic signed [25:0] upd_sum;
    logic signed [15:0] upd_sat;

    logic               accept, fin, fin_zero;
    logic signed [13:0] diff;
    logic [12:0]        one_minus_o;
    logic [12:0]        h_sel;
    logic [1:0]         cls;
    logic [31:0]        widx32;

    assign busy       = (r_state != ST_IDLE);
    assign accept     = start && !busy;
    assign rd_eff     = r_rdv ? r_rd : 16'sd0;
    assign pipe_empty = !(r_t1v || r_t2v || r_t3v || r_t4v);
    assign diff       = 14'($signed({1'b0, r_tgt})) - 14'($signed({1'b0, r_o}));
    assign one_minus_o = ONE_Q12 - r_o;
    assign h_sel      = r_h[r_j];
    assign widx32     = 32'(i_item.weight_index);

    // Controller: next state, memory address, multiplier operands.
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_step    = r_step;
        ra        = '0;
        iss_v     = 1'b0;
        iss_first = 1'b0;
        iss_last  = 1'b0;
        iss_out   = 1'b0;
        iss_j     = r_j;
        iss_op    = r_x[r_i];
        upd_iss   = 1'b0;
        mul_a     = 34'(rd_eff);
        mul_b     = 24'(r_op);
        fin       = 1'b0;
        fin_zero  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.req_type == REQ_TRAIN || i_item.req_type == REQ_EVAL) begin
                        n_state = ST_FWD_H;
                        n_i     = '0;
                        n_j     = JW'(1);
                    end else begin
                        fin      = 1'b1;
                        fin_zero = 1'b1;
                    end
                end
            end
            ST_FWD_H: begin
                ra        = AW'(32'(r_i) * HIDDEN_UNITS + 32'(r_j) - 1);
                iss_v     = 1'b1;
                iss_first = (r_i == '0);
                iss_last  = (32'(r_i) == INPUT_UNITS - 1);
                if (32'(r_i) == INPUT_UNITS - 1) begin
                    n_i = '0;
                    if (32'(r_j) == HIDDEN_UNITS) begin
                        n_state = ST_WAIT_H;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_WAIT_H: begin
                if (pipe_empty) begin
                    n_state = ST_FWD_O;
                    n_j     = '0;
                end
            end
            ST_FWD_O: begin
                ra        = AW'(IH + 32'(r_j));
                iss_v     = 1'b1;
                iss_first = (r_j == '0);
                iss_last  = (32'(r_j) == HIDDEN_UNITS);
                iss_out   = 1'b1;
                iss_op    = 16'($signed({1'b0, h_sel}));
                if (32'(r_j) == HIDDEN_UNITS) begin
                    n_state = ST_WAIT_O;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_WAIT_O: begin
                if (pipe_empty) begin
                    n_state = ST_SCAL;
                    n_step  = '0;
                end
            end
            ST_SCAL: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    3'd0: begin
                        mul_a = 34'(diff);
                        mul_b = 24'(diff);
                    end
                    3'd1: begin
                        mul_a = 34'($signed({1'b0, r_o}));
                        mul_b = 24'($signed({1'b0, one_minus_o}));
                    end
                    3'd2: begin
                        mul_a = 34'(diff);
                        mul_b = 24'(r_prod);
                        if (r_req == REQ_EVAL) begin
                            n_state = ST_IDLE;
                            fin     = 1'b1;
                        end
                    end
                    3'd3: begin
                        mul_a = 34'($signed({1'b0, r_lr}));
                        mul_b = 24'(r_prod >>> 24);
                    end
                    default: begin
                        n_state = ST_DH;
                        n_step  = '0;
                        n_j     = JW'(1);
                    end
                endcase
            end
            ST_DH: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    3'd0: begin
                        ra    = AW'(IH + 32'(r_j));
                        mul_a = 34'($signed({1'b0, h_sel}));
                        mul_b = 24'($signed({1'b0, ONE_Q12 - h_sel}));
                    end
                    3'd1: begin
                        mul_a = 34'(rd_eff);
                        mul_b = 24'(r_do);
                    end
                    3'd2: begin
                        mul_a = 34'(r_prod);
                        mul_b = r_q;
                    end
                    3'd3: begin
                        mul_a = 34'($signed({1'b0, r_lr}));
                        mul_b = 24'(r_prod >>> 36);
                    end
                    default: begin
                        n_step = '0;
                        if (32'(r_j) == HIDDEN_UNITS) begin
                            n_state = ST_UPD;
                            n_i     = '0;
                            n_j     = JW'(1);
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                endcase
            end
            ST_UPD: begin
                upd_iss = 1'b1;
                if (r_step == '0) begin
                    ra    = AW'(32'(r_i) * HIDDEN_UNITS + 32'(r_j) - 1);
                    mul_a = r_lrdh[r_j];
                    mul_b = 24'(r_x[r_i]);
                    if (32'(r_j) == HIDDEN_UNITS) begin
                        n_j = JW'(1);
                        if (32'(r_i) == INPUT_UNITS - 1) begin
                            n_step = 3'd1;
                            n_j    = '0;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    ra    = AW'(IH + 32'(r_j));
                    mul_a = r_lrdo;
                    mul_b = 24'($signed({1'b0, h_sel}));
                    if (32'(r_j) == HIDDEN_UNITS) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                n_state = ST_IDLE;
                fin     = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Accumulate, clamp and table index.
    always_comb begin
        acc_next = r_t2first ? 40'(r_prod) : r_acc + 40'(r_prod);
        acc_shr  = acc_next >>> 12;
        if (acc_shr > 40'sd32767) begin
            sum_clamp = 16'sd32767;
        end else if (acc_shr < -40'sd32768) begin
            sum_clamp = -16'sd32768;
        end else begin
            sum_clamp = 16'(acc_shr);
        end
        sidx_wide = 32'({~r_sum[15], r_sum[14:0]}) * 32'(SIGMOID_DEPTH);
    end

    // Weight update: add the scaled step and saturate; else take a weight write request.
    always_comb begin
        upd_sum = 26'(rd_eff) + 26'(r_prod >>> 24);
        if (upd_sum > 26'sd32767) begin
            upd_sat = 16'sd32767;
        end else if (upd_sum < -26'sd32768) begin
            upd_sat = -16'sd32768;
        end else begin
            upd_sat = 16'(upd_sum);
        end
        mem_we = 1'b0;
        wa     = r_u1addr;
        wd     = upd_sat;
        if (r_u1v) begin
            mem_we = 1'b1;
        end else if (accept && i_item.req_type == REQ_WRITE && widx32 < NW) begin
            mem_we = 1'b1;
            wa     = AW'(widx32);
            wd     = i_item.weight_value;
        end
    end

    always_comb begin
        if (r_o <= CLASS_LOW_MAX) begin
            cls = CLASS_LOW;
        end else if (r_o >= CLASS_HIGH_MIN) begin
            cls = CLASS_HIGH;
        end else begin
            cls = CLASS_UNDEC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wa] <= wd;
        end
        r_rd  <= r_mem[ra];
        r_rdv <= r_wvalid[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_step   <= '0;
            r_lr     <= LEARN_RATE_RESET;
            r_wvalid <= '0;
            r_t1v    <= 1'b0;
            r_t2v    <= 1'b0;
            r_t3v    <= 1'b0;
            r_t4v    <= 1'b0;
            r_u1v    <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_step  <= n_step;
            if (i_cfg_we) begin
                r_lr <= i_cfg_data;
            end
            if (mem_we) begin
                r_wvalid[wa] <= 1'b1;
            end
            r_t1v    <= iss_v;
            r_t2v    <= r_t1v;
            r_t3v    <= r_t2v && r_t2last;
            r_t4v    <= r_t3v;
            r_u1v    <= upd_iss;
            o_strobe <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (accept) begin
            r_req <= i_item.req_type;
            r_tgt <= (i_item.target > ONE_Q12) ? ONE_Q12 : i_item.target;
            // Unit 0 is the bias, units beyond the two pattern inputs stay zero.
            for (int n = 0; n < INPUT_UNITS; n++) begin
                if (n == 0) begin
                    r_x[n] <= 16'($signed({1'b0, ONE_Q12}));
                end else if (n == 1) begin
                    r_x[n] <= i_item.input_a;
                end else if (n == 2) begin
                    r_x[n] <= i_item.input_b;
                end else begin
                    r_x[n] <= 16'sd0;
                end
            end
            r_h[0]    <= ONE_Q12;
            r_lrdh[0] <= '0;
        end
        r_t1first <= iss_first;
        r_t1last  <= iss_last;
        r_t1out   <= iss_out;
        r_t1j     <= iss_j;
        r_op      <= iss_op;
        r_t2first <= r_t1first;
        r_t2last  <= r_t1last;
        r_t2out   <= r_t1out;
        r_t2j     <= r_t1j;
        if (r_t2v) begin
            r_acc <= acc_next;
            r_sum <= sum_clamp;
        end
        r_t3out <= r_t2out;
        r_t3j   <= r_t2j;
        r_sidx  <= sidx_wide[16 +: SW];
        r_t4out <= r_t3out;
        r_t4j   <= r_t3j;
        if (r_t4v) begin
            if (r_t4out) begin
                r_o <= w_rom[r_sidx];
            end else begin
                r_h[r_t4j] <= w_rom[r_sidx];
            end
        end
        if (r_state == ST_SCAL && r_step == 3'd1) begin
            r_err <= r_prod[24:13];
        end
        if (r_state == ST_SCAL && r_step == 3'd3) begin
            r_do <= 16'(r_prod >>> 24);
        end
        if (r_state == ST_SCAL && r_step == 3'd4) begin
            r_lrdo <= 34'(r_prod);
        end
        if (r_state == ST_DH && r_step == 3'd1) begin
            r_q <= 24'(r_prod);
        end
        if (r_state == ST_DH && r_step == 3'd4) begin
            r_lrdh[r_j] <= 34'(r_prod);
        end
        r_u1addr <= ra;
        if (fin) begin
            if (fin_zero) begin
                o_result <= '0;
            end else begin
                o_result.net_output    <= r_o;
                o_result.pattern_error <= r_err;
                o_result.class_code    <= cls;
                o_result.hit           <= (cls == CLASS_LOW && r_tgt == '0) ||
                                          (cls == CLASS_HIGH && r_tgt == ONE_Q12);
            end
        end
    end

    // A weight write or unknown request answers in the next cycle.
    a_write_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.req_type != REQ_TRAIN && i_item.req_type != REQ_EVAL)
        |=> o_strobe)
        else $error("write request without result");

    // A result only appears once the sequencer is back to accepting items.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result while busy");

    // The scalar delta steps must find the forward pipeline drained.
    a_pipe_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAL || r_state == ST_DH) |-> pipe_empty)
        else $error("forward pipeline still active");

    // Update write-back never overlaps a forward transaction in flight.
    a_upd_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u1v |-> !r_t1v && !iss_v)
        else $error("update overlaps forward pass");

endmodule
